// ===== rtl/tlvp_pkg.sv =====
// ----------------------------------------------------------------------------
// tlvp_pkg
// Shared types, codes and helper functions for the TLV archive parser.
// ----------------------------------------------------------------------------
`default_nettype none

package tlvp_pkg;

  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic [31:0] ARC_MAGIC  = 32'h5A5A_4B31;
  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
  localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
  localparam logic [31:0] HDR_BYTES  = 32'd12;
  localparam logic [31:0] TYPE_TXT   = 32'h0000_0001;
  localparam logic [31:0] TYPE_BIN   = 32'h0000_0002;
  localparam logic [31:0] TYPE_PAD   = 32'hFFFF_FFFF;

  // register index decoded from paddr
  localparam logic REG_TARGET = 1'b0;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_FINAL   = 2'd2;

  // type classes
  localparam logic [1:0] CLASS_TEXT    = 2'd0;
  localparam logic [1:0] CLASS_BINARY  = 2'd1;
  localparam logic [1:0] CLASS_PADDING = 2'd2;
  localparam logic [1:0] CLASS_UNKNOWN = 2'd3;

  // final status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC  = 3'd1;
  localparam logic [2:0] ST_BAD_SIZE   = 3'd2;
  localparam logic [2:0] ST_OVERRUN    = 3'd3;
  localparam logic [2:0] ST_TRUNCATED  = 3'd4;
  localparam logic [2:0] ST_NO_TARGET  = 3'd5;

  typedef enum logic [10:0] {
    PH_MAGIC     = 11'b000_0000_0001,
    PH_SIZE      = 11'b000_0000_0010,
    PH_RESV      = 11'b000_0000_0100,
    PH_TYPE      = 11'b000_0000_1000,
    PH_LEN       = 11'b000_0001_0000,
    PH_VALUE     = 11'b000_0010_0000,
    PH_CRC       = 11'b000_0100_0000,
    PH_DONE      = 11'b000_1000_0000,
    PH_ERR_MAGIC = 11'b001_0000_0000,
    PH_ERR_SIZE  = 11'b010_0000_0000,
    PH_ERR_OVR   = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [30:0] chunk_number;
    logic [31:0] chunk_kind;
    logic [1:0]  type_class;
    logic [31:0] value_len;
    logic        crc_ok;
    logic [2:0]  status;
  } result_t;

  // reflected crc-32, one byte, bit at a time
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [1:0] class_of(input logic [31:0] t);
    logic [1:0] cls;
    if (t == TYPE_TXT) begin
      cls = CLASS_TEXT;
    end else if (t == TYPE_BIN) begin
      cls = CLASS_BINARY;
    end else if (t == TYPE_PAD) begin
      cls = CLASS_PADDING;
    end else begin
      cls = CLASS_UNKNOWN;
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tlv_archive_parser_crc_check.sv =====
// ----------------------------------------------------------------------------
// tlv_archive_parser_crc_check
// Byte-stream TLV archive parser with per-chunk CRC-32 check.
// ----------------------------------------------------------------------------
// Takes one archive byte per beat and handles each byte in the cycle it is
// accepted, so the sustained rate is one beat per clock while in_stall is
// low. The header check, chunk parsing and the byte-wide CRC-32 update all
// sit between the parser state registers and a two-entry output stage (output
// register plus skid register). in_stall rises only when both output entries
// hold a result, i.e. after the consumer has stalled for more than one
// result. Payload bytes of the chunk chosen by target_chunk, one summary per
// chunk and one final status per end-of-stream beat come out in stream order.
// After the final status the parser is back in its reset state and a new
// archive may follow. target_chunk is written through the APB port at address 0.
`default_nettype none

module tlv_archive_parser_crc_check
  import tlvp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  // input beats
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        byte_value,
  input  wire logic              stream_end,
  // result beats
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [1:0]        kind,
  output logic      [7:0]        data_byte,
  output logic      [30:0]       chunk_number,
  output logic      [31:0]       chunk_kind,
  output logic      [1:0]        type_class,
  output logic      [31:0]       value_len,
  output logic                   crc_ok,
  output logic      [2:0]        status
);

  // configuration register
  logic [30:0] target_chunk;

  // parser state
  phase_t      phase,        phase_next;
  logic [1:0]  field_cnt,    field_cnt_next;
  logic [31:0] word_shift,   word_shift_next;
  logic [31:0] region_left,  region_left_next;
  logic [31:0] current_type, current_type_next;
  logic [31:0] current_len,  current_len_next;
  logic [31:0] payload_left, payload_left_next;
  logic [31:0] running_crc,  running_crc_next;
  logic [30:0] chunks_seen,  chunks_seen_next;
  logic        target_seen,  target_seen_next;

  // output stage
  logic        skid_valid;
  result_t     out_res;
  result_t     skid_res;
  result_t     res;
  logic        res_fire;

  logic        in_take;
  logic        out_take;
  logic        cfg_write;

  logic [31:0] word_full;
  logic        word_last;
  logic [31:0] crc_upd;
  logic [33:0] len_fit;
  logic [30:0] count_inc;
  logic        is_target;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_TARGET) ? {1'b0, target_chunk} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_chunk <= '0;
    end else if (cfg_write && paddr[2] == REG_TARGET) begin
      target_chunk <= pwdata[30:0];
    end
  end

  assign in_stall = skid_valid;
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  assign word_full  = {word_shift[23:0], byte_value};
  assign word_last  = (field_cnt == 2'd3);
  assign crc_upd    = crc32_byte(running_crc, byte_value);
  // negative when the chunk's header, value and crc do not fit in the region
  assign len_fit    = {2'b0, region_left} - ({2'b0, word_full} + 34'(HDR_BYTES));
  assign count_inc  = chunks_seen + 31'd1;
  assign is_target  = (target_chunk != '0) && (chunks_seen == target_chunk);

  always_comb begin
    phase_next        = phase;
    field_cnt_next    = field_cnt;
    word_shift_next   = word_shift;
    region_left_next  = region_left;
    current_type_next = current_type;
    current_len_next  = current_len;
    payload_left_next = payload_left;
    running_crc_next  = running_crc;
    chunks_seen_next  = chunks_seen;
    target_seen_next  = target_seen;
    res               = '0;
    res_fire          = 1'b0;

    if (stream_end) begin
      res_fire          = 1'b1;
      res.kind          = KIND_FINAL;
      res.chunk_number  = chunks_seen;
      case (phase)
        PH_MAGIC, PH_ERR_MAGIC: res.status = ST_BAD_MAGIC;
        PH_ERR_SIZE:            res.status = ST_BAD_SIZE;
        PH_ERR_OVR:             res.status = ST_OVERRUN;
        PH_TYPE, PH_DONE: begin
          res.status = (target_chunk != '0 && !target_seen) ? ST_NO_TARGET : ST_OK;
        end
        default:                res.status = ST_TRUNCATED;
      endcase
      phase_next        = PH_MAGIC;
      field_cnt_next    = '0;
      word_shift_next   = '0;
      region_left_next  = '0;
      current_type_next = '0;
      current_len_next  = '0;
      payload_left_next = '0;
      running_crc_next  = ALL_ONES;
      chunks_seen_next  = '0;
      target_seen_next  = 1'b0;
    end else begin
      case (phase)
        PH_MAGIC: begin
          word_shift_next = word_full;
          field_cnt_next  = field_cnt + 2'd1;
          if (word_last) begin
            phase_next = (word_full == ARC_MAGIC) ? PH_SIZE : PH_ERR_MAGIC;
          end
        end
        PH_SIZE: begin
          word_shift_next = word_full;
          field_cnt_next  = field_cnt + 2'd1;
          if (word_last) begin
            region_left_next = word_full;
            phase_next       = PH_RESV;
          end
        end
        PH_RESV: begin
          word_shift_next = word_full;
          field_cnt_next  = field_cnt + 2'd1;
          if (word_last) begin
            if (region_left < HDR_BYTES) begin
              phase_next = PH_ERR_SIZE;
            end else begin
              region_left_next = region_left - HDR_BYTES;
              running_crc_next = ALL_ONES;
              phase_next = ((region_left - HDR_BYTES) < 32'd8) ? PH_DONE : PH_TYPE;
            end
          end
        end
        PH_TYPE: begin
          running_crc_next = crc_upd;
          word_shift_next  = word_full;
          field_cnt_next   = field_cnt + 2'd1;
          if (word_last) begin
            current_type_next = word_full;
            phase_next        = PH_LEN;
          end
        end
        PH_LEN: begin
          running_crc_next = crc_upd;
          word_shift_next  = word_full;
          field_cnt_next   = field_cnt + 2'd1;
          if (word_last) begin
            current_len_next = word_full;
            if (len_fit[33]) begin
              phase_next = PH_ERR_OVR;
            end else begin
              // region left after this chunk's header, value and crc
              region_left_next  = len_fit[31:0];
              chunks_seen_next  = count_inc;
              if (target_chunk != '0 && count_inc == target_chunk) begin
                target_seen_next = 1'b1;
              end
              payload_left_next = word_full;
              phase_next        = (word_full != '0) ? PH_VALUE : PH_CRC;
            end
          end
        end
        PH_VALUE: begin
          running_crc_next  = crc_upd;
          payload_left_next = payload_left - 32'd1;
          if (payload_left == 32'd1) begin
            phase_next = PH_CRC;
          end
          if (is_target) begin
            res_fire         = 1'b1;
            res.kind         = KIND_PAYLOAD;
            res.data_byte    = byte_value;
            res.chunk_number = chunks_seen;
            res.chunk_kind   = current_type;
            res.type_class   = class_of(current_type);
            res.value_len    = current_len;
          end
        end
        PH_CRC: begin
          word_shift_next = word_full;
          field_cnt_next  = field_cnt + 2'd1;
          if (word_last) begin
            res_fire         = 1'b1;
            res.kind         = KIND_SUMMARY;
            res.chunk_number = chunks_seen;
            res.chunk_kind   = current_type;
            res.type_class   = class_of(current_type);
            res.value_len    = current_len;
            res.crc_ok       = (word_full == ~running_crc);
            running_crc_next = ALL_ONES;
            phase_next       = (region_left < 32'd8) ? PH_DONE : PH_TYPE;
          end
        end
        default: begin
          // done or error: bytes are ignored until end of stream
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_MAGIC;
      field_cnt    <= '0;
      word_shift   <= '0;
      region_left  <= '0;
      current_type <= '0;
      current_len  <= '0;
      payload_left <= '0;
      running_crc  <= ALL_ONES;
      chunks_seen  <= '0;
      target_seen  <= 1'b0;
    end else if (in_take) begin
      phase        <= phase_next;
      field_cnt    <= field_cnt_next;
      word_shift   <= word_shift_next;
      region_left  <= region_left_next;
      current_type <= current_type_next;
      current_len  <= current_len_next;
      payload_left <= payload_left_next;
      running_crc  <= running_crc_next;
      chunks_seen  <= chunks_seen_next;
      target_seen  <= target_seen_next;
    end
  end

  // output register plus skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= in_take && res_fire;
      end
    end else if (in_take && res_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (in_take && res_fire) begin
        out_res <= res;
      end
    end else if (in_take && res_fire) begin
      skid_res <= res;
    end
  end

  assign kind         = out_res.kind;
  assign data_byte    = out_res.data_byte;
  assign chunk_number = out_res.chunk_number;
  assign chunk_kind   = out_res.chunk_kind;
  assign type_class   = out_res.type_class;
  assign value_len    = out_res.value_len;
  assign crc_ok       = out_res.crc_ok;
  assign status       = out_res.status;

endmodule

`default_nettype wire
